// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define SLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication checked in the cycle after the condition.
`define SLE_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/sle_pkg.sv =====
`default_nettype none

package sle_pkg;

    localparam int CAPACITY  = 64;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 7;
    localparam int VAL_W     = 32;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic load;
        logic compare;
        logic apply;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/sle_dp.sv =====
`default_nettype none

`include "assert_macros.svh"

module sle_dp
    import sle_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_dp_cmd                     i_cmd,
    input  wire logic [OP_W-1:0]             i_operation,
    input  wire logic signed [VAL_W-1:0]     i_value,
    output logic                             o_hit,
    output logic                             o_rejected_full,
    output logic [OUT_CNT_W-1:0]             o_entry_count
);

    localparam int CNTX_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

    logic [OP_W-1:0]          r_op;
    logic signed [VAL_W-1:0]  r_value;
    logic signed [VAL_W-1:0]  r_entry [CAPACITY];
    logic signed [VAL_W-1:0]  n_entry [CAPACITY];
    logic [CAPACITY-1:0]      r_lt;
    logic [CAPACITY-1:0]      r_eq;
    logic [CAPACITY-1:0]      n_lt;
    logic [CAPACITY-1:0]      n_eq;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_res_hit;
    logic                     r_res_full;
    logic [OUT_CNT_W-1:0]     r_res_count;
    logic                     n_res_hit;
    logic                     n_res_full;
    logic [CNTX_W-1:0]        count_ext;
    logic                     full;
    logic                     hit_any;
    logic                     do_ins;
    logic                     do_del;

    assign full    = (r_count == CNT_W'(CAPACITY));
    assign hit_any = |r_eq;
    assign do_ins  = i_cmd.apply && (r_op == OP_INSERT) && !full;
    assign do_del  = i_cmd.apply && (r_op == OP_DELETE) && hit_any;

    // per-cell compare against the broadcast operand
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_lt[i] = (CNT_W'(i) < r_count) && (r_entry[i] < r_value);
            n_eq[i] = (CNT_W'(i) < r_count) && (r_entry[i] == r_value);
        end
    end

    // cells at or after the split point shift right on insert, left on delete
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == CAPACITY - 1) ? g : g + 1;
        always_comb begin
            n_entry[g] = r_entry[g];
            if (do_ins && !r_lt[g]) begin
                if (g == 0) begin
                    n_entry[g] = r_value;
                end else begin
                    n_entry[g] = r_lt[PREV] ? r_value : r_entry[PREV];
                end
            end else if (do_del && !r_lt[g]) begin
                n_entry[g] = r_entry[NEXT];
            end
        end
    end

    always_comb begin
        n_count    = r_count;
        n_res_hit  = 1'b0;
        n_res_full = 1'b0;
        case (r_op)
            OP_INSERT: begin
                if (full) begin
                    n_res_full = 1'b1;
                end else begin
                    n_res_hit = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            OP_SEARCH: begin
                n_res_hit = hit_any;
            end
            OP_DELETE: begin
                n_res_hit = hit_any;
                if (hit_any) begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign count_ext = CNTX_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
        if (i_cmd.compare) begin
            r_lt <= n_lt;
            r_eq <= n_eq;
        end
        if (i_cmd.apply) begin
            r_res_hit   <= n_res_hit;
            r_res_full  <= n_res_full;
            r_res_count <= count_ext[OUT_CNT_W-1:0];
        end
        for (int i = 0; i < CAPACITY; i++) begin
            r_entry[i] <= n_entry[i];
        end
    end

    assign o_hit           = r_res_hit;
    assign o_rejected_full = r_res_full;
    assign o_entry_count   = r_res_count;

    `SLE_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `SLE_ASSERT_NEXT(a_full_reject,
        i_cmd.apply && (r_op == OP_INSERT) && full,
        r_res_full && !r_res_hit && (r_count == CNT_W'(CAPACITY)),
        "insert into full store not rejected")
    `SLE_ASSERT_NEXT(a_del_count, do_del,
        r_count == $past(r_count) - 1'b1, "delete hit without count drop")
    `SLE_ASSERT_NEXT(a_hit_search, i_cmd.apply && (r_op == OP_SEARCH),
        r_res_hit == $past(hit_any) && $stable(r_count), "search result mismatch")

endmodule

`default_nettype wire

// ===== rtl/sle_ctrl.sv =====
`default_nettype none

module sle_ctrl
    import sle_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_in_ready    = (r_state == S_IDLE) || ((r_state == S_APPLY) && out_free);
        o_cmd.load    = i_in_valid && o_in_ready;
        o_cmd.compare = (r_state == S_CMP);
        o_cmd.apply   = (r_state == S_APPLY) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.apply) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (out_free) begin
                        r_state <= o_cmd.load ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/sorted_list_engine.sv =====
// Sorted store of up to 64 signed 32-bit values, one request per stream
// item: insert (ahead of equal values), search, or delete of the first
// match. Each request returns one result with a hit flag, a full-reject
// flag and the entry count after the request. A request passes through
// a compare step, in which every cell compares its entry with the
// operand, and an apply step, in which the cell array shifts; a new
// request is taken during the apply step while the output side keeps
// up. The result sits in an output register, so the next request is
// accepted while it waits.
`default_nettype none

module sorted_list_engine
    import sle_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] operation
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata    // [0] hit, [1] rejected_full, [8:2] entry_count
);

    t_dp_cmd              cmd;
    logic                 hit;
    logic                 rejected_full;
    logic [OUT_CNT_W-1:0] entry_count;

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    sle_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_s_axis_tuser),
        .i_value         (i_s_axis_tdata),
        .o_hit           (hit),
        .o_rejected_full (rejected_full),
        .o_entry_count   (entry_count)
    );

    assign o_m_axis_tdata = {7'd0, entry_count, rejected_full, hit};

endmodule

`default_nettype wire

// ===== sim/sle_checker.sv =====
`timescale 1ns / 1ps

module sle_checker
    import sle_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [31:0]  i_s_tdata,   // [31:0] value
    input  wire logic [1:0]   i_s_tuser,   // [1:0] operation
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [15:0]  i_m_tdata,   // [0] hit, [1] rejected_full, [8:2] entry_count
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic                 hit;
        logic                 rejected_full;
        logic [OUT_CNT_W-1:0] entry_count;
    } t_list_result;

    logic signed [VAL_W-1:0] list_store [CAPACITY];
    int                      list_count = 0;
    t_list_result            expected_q [$];

    function automatic t_list_result predict_list_op(input logic [OP_W-1:0] op,
                                                     input logic signed [VAL_W-1:0] v);
        t_list_result res;
        int           pos;
        int           i;
        res = '0;
        case (op)
            OP_INSERT: begin
                if (list_count >= CAPACITY) begin
                    res.rejected_full = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < list_count && list_store[pos] < v)
                        pos++;
                    for (i = list_count; i > pos; i--)
                        list_store[i] = list_store[i-1];
                    list_store[pos] = v;
                    list_count++;
                    res.hit = 1'b1;
                end
            end
            OP_SEARCH: begin
                for (i = 0; i < list_count; i++)
                    if (list_store[i] == v)
                        res.hit = 1'b1;
            end
            OP_DELETE: begin
                pos = -1;
                for (i = 0; i < list_count && pos < 0; i++)
                    if (list_store[i] == v)
                        pos = i;
                if (pos >= 0) begin
                    for (i = pos; i + 1 < list_count; i++)
                        list_store[i] = list_store[i+1];
                    list_count--;
                    res.hit = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = OUT_CNT_W'(list_count);
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            list_count = 0;
            expected_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_q.push_back(predict_list_op(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.hit           = i_m_tdata[0];
                got.rejected_full = i_m_tdata[1];
                got.entry_count   = i_m_tdata[8:2];
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result hit=%0d rej=%0d count=%0d", $time,
                             got.hit, got.rejected_full, got.entry_count);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit expected %0d actual %0d", $time,
                                 want.hit, got.hit);
                        o_fail_count++;
                    end
                    if (got.rejected_full !== want.rejected_full) begin
                        $display("%0t: rejected_full expected %0d actual %0d", $time,
                                 want.rejected_full, got.rejected_full);
                        o_fail_count++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count expected %0d actual %0d", $time,
                                 want.entry_count, got.entry_count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import sle_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int CALM_ITEMS     = 150;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT        = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} t_mix_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    int          fail_count;
    int          pending;
    int          req_sent = 0;
    bit          calm = 1'b0;
    int          recent_vals [$];

    always #4 i_clk = ~i_clk;

    sorted_list_engine u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    sle_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    task automatic send_request(input logic [1:0] op, input logic signed [31:0] v);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
        req_sent++;
        if (op == OP_INSERT) begin
            recent_vals.push_back(v);
            if (recent_vals.size() > CAPACITY)
                void'(recent_vals.pop_front());
        end
    endtask

    function automatic logic signed [31:0] small_value();
        int r;
        r = $urandom_range(0, 8);
        return r - 4;
    endfunction

    function automatic logic signed [31:0] insert_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return small_value();
        if (r == 4)
            return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
        return $urandom;
    endfunction

    function automatic logic signed [31:0] probe_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && recent_vals.size() > 0)
            return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
        if (r < 8)
            return small_value();
        if (r == 8)
            return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
        return $urandom;
    endfunction

    // downstream ready: random stalls, one long hold-off to back up the engine
    initial begin : receiver
        int  stall_left;
        bit  held;
        stall_left = 0;
        held       = 1'b0;
        m_tready   = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!held && req_sent >= HOLD_AT) begin
                held       = 1'b1;
                stall_left = LONG_HOLD - 1;
                m_tready   <= 1'b0;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        wait (i_rst_n === 1'b1);
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int        n_left;
        int        phase_len;
        int        r;
        bit        first;
        t_mix_mode mode;
        logic [1:0] op;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        i_rst_n  = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, no-op code, extremes, duplicates, misses
        send_request(OP_SEARCH, 32'sd0);
        send_request(OP_DELETE, 32'sd5);
        send_request(OP_NOP,    VAL_MAX);
        send_request(OP_INSERT, VAL_MAX);
        send_request(OP_INSERT, VAL_MIN);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_INSERT, 32'sd1);
        send_request(OP_SEARCH, VAL_MAX);
        send_request(OP_SEARCH, VAL_MIN);
        send_request(OP_SEARCH, 32'sd42);
        send_request(OP_DELETE, 32'sd42);
        send_request(OP_DELETE, 32'sd0);
        send_request(OP_SEARCH, 32'sd0);
        send_request(OP_NOP,    -32'sd1);
        send_request(OP_DELETE, VAL_MIN);
        send_request(OP_DELETE, VAL_MAX);
        send_request(OP_DELETE, -32'sd1);
        send_request(OP_DELETE, 32'sd1);
        send_request(OP_DELETE, 32'sd0);
        send_request(OP_SEARCH, VAL_MIN);

        // phases pick fill, drain or mixed at random; the first fills past capacity
        n_left = RANDOM_ITEMS;
        first  = 1'b1;
        while (n_left > 0) begin
            if (first) begin
                mode      = MODE_FILL;
                phase_len = 110;
                first     = 1'b0;
            end else begin
                r         = $urandom_range(0, 2);
                mode      = t_mix_mode'(r);
                phase_len = $urandom_range(50, 110);
            end
            for (int k = 0; k < phase_len && n_left > 0; k++) begin
                if (n_left <= CALM_ITEMS)
                    calm = 1'b1;
                r = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:
                        op = r < 85 ? OP_INSERT : r < 93 ? OP_SEARCH : r < 98 ? OP_DELETE
                                                                             : OP_NOP;
                    MODE_DRAIN:
                        op = r < 20 ? OP_INSERT : r < 40 ? OP_SEARCH : r < 97 ? OP_DELETE
                                                                             : OP_NOP;
                    default:
                        op = r < 40 ? OP_INSERT : r < 65 ? OP_SEARCH : r < 95 ? OP_DELETE
                                                                             : OP_NOP;
                endcase
                send_request(op, op == OP_INSERT ? insert_value() : probe_value());
                n_left--;
            end
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
